### src/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg: shared types and constants of the bitmap identifier allocator
// Sizes of the in-use map and its word layout, payload structs and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam int unsigned NUM_IDS = 1024;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROWS    = NUM_IDS / WORD_W;
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned BIT_W   = $clog2(WORD_W);
  localparam int unsigned SLOT_W  = ROW_W + BIT_W;
  localparam int unsigned CNT_W   = $clog2(NUM_IDS + 1);
  localparam int unsigned ID_W    = 17;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(100);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_SPARE   = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NOT_USED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REL_CHK,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_count;
    logic [ID_W-1:0]   first_free_id;
    logic              none_free;
  } rsp_t;

  // find-first-zero result of one map word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_res_t;

endpackage

`default_nettype wire

### src/bia_ram.sv
// ----------------------------------------------------------------------------
// bia_ram: generic single-clock RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/bia_ffz.sv
// ----------------------------------------------------------------------------
// bia_ffz: find-first-zero unit
// Binary search for the lowest clear bit of one map word.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ffz (
  input  wire  [bia_pkg::WORD_W-1:0] word_i,
  output bia_pkg::ffz_res_t          res_o
);
  import bia_pkg::*;

  always_comb begin
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] win;
    logic [WORD_W-1:0] mask;
    logic [BIT_W-1:0]  pos;
    int unsigned       half;
    free_bits = ~word_i;
    pos       = '0;
    for (int l = BIT_W - 1; l >= 0; l--) begin
      half = 1 << l;
      win  = free_bits >> pos;
      mask = {WORD_W{1'b1}} >> (WORD_W - half);
      // low half of the window empty: move to the upper half
      if ((win & mask) == '0) begin
        pos = pos | BIT_W'(half);
      end
    end
    res_o.found = |free_bits;
    res_o.pos   = pos;
  end

endmodule

`default_nettype wire

### src/bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator: first-fit identifier allocator over an in-use bitmap
// Sequencer, map memory and word scan for allocate, release and status.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the word is taken at a clock edge where
// start is high and busy is low. busy stays high while the item is worked on.
// The result is shown on result_o for one cycle with result_valid_o high, in
// the first cycle busy is low again; the receiver has no way to stall it, and
// a new word may be taken at the edge that ends that cycle. base_id is written
// through cfg_valid_i / cfg_data_i; cfg_ready_o is high only while idle with
// no word offered, so a write never lands on an item in flight.
// The map is 32 words of 32 bits in a RAM, scanned one word per cycle through
// one find-first-zero unit. A scan stops at the first word with a clear bit
// or after the last word. A status item is one scan; a release in range checks
// its word first and then scans; an allocate scans up to the granted word and
// then rescans from that word.
// Reset clears a valid bit per map word at once, so every identifier is free
// right after reset with no clearing pass; base_id returns to 100.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  bia_pkg::req_t              req_i,
  output logic                       result_valid_o,
  output bia_pkg::rsp_t              result_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [bia_pkg::BASE_W-1:0] cfg_data_i
);
  import bia_pkg::*;

  state_e            state_q, state_d;
  logic              alloc_pass_q, alloc_pass_d;
  logic [ROW_W:0]    scan_row_q, scan_row_d;
  logic              eval_vld_q, eval_vld_d;
  logic [ROW_W-1:0]  eval_row_q, eval_row_d;
  logic [SLOT_W-1:0] rel_slot_q, rel_slot_d;
  status_e           status_q, status_d;
  logic [ID_W-1:0]   granted_q, granted_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [BASE_W-1:0] base_q;
  logic [ROWS-1:0]   row_vld_q, row_vld_d;
  rsp_t              res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [WORD_W-1:0] scan_word;
  ffz_res_t          ffz;

  // release range check on the incoming word
  logic [ID_W-1:0]   rel_lo;
  logic [ID_W-1:0]   rel_diff;
  logic              rel_oor;
  logic [SLOT_W-1:0] rel_idx;

  assign rel_lo   = ID_W'({1'b0, base_q}) + ID_W'(1);
  assign rel_diff = req_i.release_id - rel_lo;
  assign rel_oor  = (req_i.release_id < rel_lo) || (rel_diff >= ID_W'(NUM_IDS));
  assign rel_idx  = rel_diff[SLOT_W-1:0];

  function automatic logic [ID_W-1:0] slot_id(logic [BASE_W-1:0] base,
                                               logic [SLOT_W-1:0] slot);
    return ID_W'({1'b0, base}) + ID_W'(slot) + ID_W'(1);
  endfunction

  bia_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // a word never written reads as all free
  assign scan_word = row_vld_q[eval_row_q] ? ram_rdata : '0;

  bia_ffz u_ffz (
    .word_i(scan_word),
    .res_o (ffz)
  );

  always_comb begin
    logic [ROW_W-1:0]  rel_row;
    logic [WORD_W-1:0] rel_word;
    logic [WORD_W-1:0] rel_mask;
    logic [SLOT_W-1:0] slot;
    rel_row      = rel_slot_q[SLOT_W-1:BIT_W];
    rel_word     = row_vld_q[rel_row] ? ram_rdata : '0;
    rel_mask     = WORD_W'(1) << rel_slot_q[BIT_W-1:0];
    slot         = {eval_row_q, ffz.pos};

    state_d      = state_q;
    alloc_pass_d = alloc_pass_q;
    scan_row_d   = scan_row_q;
    eval_vld_d   = eval_vld_q;
    eval_row_d   = eval_row_q;
    rel_slot_d   = rel_slot_q;
    status_d     = status_q;
    granted_d    = granted_q;
    free_d       = free_q;
    row_vld_d    = row_vld_q;
    res_d        = res_q;
    res_vld_d    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = eval_row_q;
    ram_wdata    = '0;
    ram_raddr    = scan_row_q[ROW_W-1:0];

    case (state_q)
      S_IDLE: begin
        ram_raddr = rel_idx[SLOT_W-1:BIT_W];
        if (start) begin
          alloc_pass_d = (req_i.kind == KIND_ALLOC);
          status_d     = STAT_OK;
          granted_d    = '0;
          scan_row_d   = '0;
          eval_vld_d   = 1'b0;
          rel_slot_d   = rel_idx;
          state_d      = S_SCAN;
          if (req_i.kind == KIND_RELEASE) begin
            if (rel_oor) begin
              status_d = STAT_RANGE;
            end else begin
              state_d = S_REL_CHK;
            end
          end
        end
      end

      S_REL_CHK: begin
        if ((rel_word & rel_mask) != '0) begin
          ram_we             = 1'b1;
          ram_waddr          = rel_row;
          ram_wdata          = rel_word & ~rel_mask;
          row_vld_d[rel_row] = 1'b1;
          free_d             = free_q + CNT_W'(1);
        end else begin
          status_d = STAT_NOT_USED;
        end
        state_d = S_SCAN;
      end

      S_SCAN: begin
        // issue the next word read; evaluate the word read last cycle
        if (scan_row_q < (ROW_W + 1)'(ROWS)) begin
          eval_vld_d = 1'b1;
          eval_row_d = scan_row_q[ROW_W-1:0];
          scan_row_d = scan_row_q + (ROW_W + 1)'(1);
        end else begin
          eval_vld_d = 1'b0;
        end
        if (eval_vld_q) begin
          if (ffz.found) begin
            if (alloc_pass_q) begin
              // claim the slot, then rescan from this word
              ram_we                = 1'b1;
              ram_waddr             = eval_row_q;
              ram_wdata             = scan_word | (WORD_W'(1) << ffz.pos);
              row_vld_d[eval_row_q] = 1'b1;
              free_d                = free_q - CNT_W'(1);
              granted_d             = slot_id(base_q, slot);
              alloc_pass_d          = 1'b0;
              scan_row_d            = {1'b0, eval_row_q};
              eval_vld_d            = 1'b0;
            end else begin
              res_d.granted_id    = granted_q;
              res_d.status        = status_q;
              res_d.free_count    = free_q;
              res_d.first_free_id = slot_id(base_q, slot);
              res_d.none_free     = 1'b0;
              res_vld_d           = 1'b1;
              state_d             = S_IDLE;
            end
          end else if (eval_row_q == ROW_W'(ROWS - 1)) begin
            // an allocate that took the last free slot still reports its id
            res_d.granted_id    = granted_q;
            res_d.status        = alloc_pass_q ? STAT_NONE_FREE : status_q;
            res_d.free_count    = free_q;
            res_d.first_free_id = '0;
            res_d.none_free     = 1'b1;
            res_vld_d           = 1'b1;
            state_d             = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      eval_vld_q <= 1'b0;
      free_q    <= CNT_W'(NUM_IDS);
      base_q    <= BASE_RESET;
      row_vld_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      eval_vld_q <= eval_vld_d;
      free_q     <= free_d;
      row_vld_q  <= row_vld_d;
      res_vld_q  <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_pass_q <= alloc_pass_d;
    scan_row_q   <= scan_row_d;
    eval_row_q   <= eval_row_d;
    rel_slot_q   <= rel_slot_d;
    status_q     <= status_d;
    granted_q    <= granted_d;
    res_q        <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  // hold base_id writes off while an item is taken or worked on
  assign cfg_ready_o    = !busy && !start;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_none_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.none_free == (result_o.free_count == '0)))
    else $error("none_free disagrees with free count");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("map written while idle");

endmodule

`default_nettype wire
